// ===== hw/rtl/sorted_key_table_assert.svh =====
// Assertion macros used by the top level of the sorted key table.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int KEY_W    = 11;
  localparam int TAG_W    = 16;
  localparam int RANK_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } skt_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BOOKED    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } skt_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EVAL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_READ_CAP,
    S_DONE
  } skt_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } skt_entry_t;

  typedef struct packed {
    skt_status_t        status;
    logic               slot_free;
    logic               entry_valid;
    logic [KEY_W-1:0]   entry_time;
    logic [TAG_W-1:0]   entry_tag;
    logic [COUNT_W-1:0] entry_count;
  } skt_res_t;

endpackage

// ===== hw/rtl/skt_if.sv =====
interface skt_in_if
  import skt_pkg::*;
();
  logic              valid;
  logic              ready;
  skt_cmd_t          command;
  logic [KEY_W-1:0]  slot_time;
  logic [TAG_W-1:0]  detail_tag;
  logic [RANK_W-1:0] rank;

  modport source (output valid, command, slot_time, detail_tag, rank, input ready);
  modport sink (input valid, command, slot_time, detail_tag, rank, output ready);
endinterface

interface skt_out_if
  import skt_pkg::*;
();
  logic               valid;
  logic               ready;
  skt_status_t        status;
  logic               slot_free;
  logic               entry_valid;
  logic [KEY_W-1:0]   entry_time;
  logic [TAG_W-1:0]   entry_tag;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, status, slot_free, entry_valid, entry_time, entry_tag,
                  entry_count, input ready);
  modport sink (input valid, status, slot_free, entry_valid, entry_time, entry_tag,
                entry_count, output ready);
endinterface

// ===== hw/rtl/skt_mem.sv =====
module skt_mem
  import skt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  skt_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output skt_entry_t    rdata
);

  skt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/skt_seq.sv =====
module skt_seq
  import skt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  skt_cmd_t          in_command,
  input  logic [KEY_W-1:0]  in_slot_time,
  input  logic [TAG_W-1:0]  in_detail_tag,
  input  logic [RANK_W-1:0] in_rank,
  output logic              in_ready,
  output logic              res_valid,
  input  logic              res_take,
  output skt_res_t          res,
  output logic [CW-1:0]     used_count,
  output logic              mem_we,
  output logic [IW-1:0]     mem_waddr,
  output skt_entry_t        mem_wdata,
  output logic [IW-1:0]     mem_raddr,
  input  skt_entry_t        mem_rdata
);

  skt_state_t        state_r, state_nxt;
  skt_cmd_t          cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [TAG_W-1:0]  tag_r;
  logic [RANK_W-1:0] rank_r;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              found_r, found_nxt;
  skt_status_t       status_r, status_nxt;
  logic              free_r, free_nxt;
  logic              evalid_r, evalid_nxt;
  skt_entry_t        entry_r, entry_nxt;

  logic          cmp_eq, cmp_gt;
  logic          is_empty, is_full, rank_out;
  logic [CW-1:0] idx_dec, idx_inc, idx_inc2;

  // One comparator serves every step of the scan.
  assign cmp_eq   = (mem_rdata.key == key_r);
  assign cmp_gt   = (mem_rdata.key > key_r);
  assign is_empty = (used_r == '0);
  assign is_full  = (32'(used_r) == CAPACITY);
  assign rank_out = (32'(rank_r) >= 32'(used_r));
  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_inc2 = idx_r + CW'(2);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_START;
      end
      S_START: begin
        unique case (cmd_r)
          CMD_READ:   state_nxt = (is_empty || rank_out) ? S_DONE : S_READ_CAP;
          CMD_DELETE: state_nxt = is_empty ? S_DONE : S_SCAN_RD;
          default:    state_nxt = S_SCAN_RD;
        endcase
      end
      S_SCAN_RD: begin
        state_nxt = (idx_r == used_r) ? S_EVAL : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_nxt = (cmp_eq || cmp_gt) ? S_EVAL : S_SCAN_RD;
      end
      S_EVAL: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            if (found_r || is_full) state_nxt = S_DONE;
            else if (idx_r == used_r) state_nxt = S_WRITE;
            else state_nxt = S_SHIFT_RD;
          end
          CMD_DELETE: begin
            if (!found_r || idx_inc == used_r) state_nxt = S_DONE;
            else state_nxt = S_SHIFT_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (cmd_r == CMD_INSERT) begin
          state_nxt = (idx_dec == pos_r) ? S_WRITE : S_SHIFT_RD;
        end else begin
          state_nxt = (idx_inc2 == used_r) ? S_DONE : S_SHIFT_RD;
        end
      end
      S_WRITE:    state_nxt = S_DONE;
      S_READ_CAP: state_nxt = S_DONE;
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    free_nxt   = free_r;
    evalid_nxt = evalid_r;
    entry_nxt  = entry_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[IW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_r[IW-1:0];
    unique case (state_r)
      S_START: begin
        idx_nxt    = '0;
        found_nxt  = 1'b0;
        status_nxt = ST_OK;
        free_nxt   = 1'b0;
        evalid_nxt = 1'b0;
        entry_nxt  = '0;
        mem_raddr  = IW'(rank_r);
        if (cmd_r == CMD_READ) begin
          if (is_empty) status_nxt = ST_EMPTY;
          else if (rank_out) status_nxt = ST_NOT_FOUND;
        end else if (cmd_r == CMD_DELETE && is_empty) begin
          status_nxt = ST_EMPTY;
        end
      end
      S_SCAN_CHK: begin
        found_nxt = cmp_eq;
        if (!(cmp_eq || cmp_gt)) idx_nxt = idx_inc;
      end
      S_EVAL: begin
        pos_nxt = idx_r;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (found_r) status_nxt = ST_BOOKED;
            else if (is_full) status_nxt = ST_FULL;
            idx_nxt = used_r;
          end
          CMD_DELETE: begin
            if (!found_r) status_nxt = ST_NOT_FOUND;
            else if (idx_inc == used_r) used_nxt = used_r - CW'(1);
          end
          default: free_nxt = !found_r;
        endcase
      end
      S_SHIFT_RD: begin
        mem_raddr = (cmd_r == CMD_INSERT) ? idx_dec[IW-1:0] : idx_inc[IW-1:0];
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          idx_nxt = idx_dec;
        end else begin
          idx_nxt = idx_inc;
          if (idx_inc2 == used_r) used_nxt = used_r - CW'(1);
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IW-1:0];
        mem_wdata = '{key: key_r, tag: tag_r};
        used_nxt  = used_r + CW'(1);
      end
      S_READ_CAP: begin
        evalid_nxt = 1'b1;
        entry_nxt  = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_command;
      key_r  <= in_slot_time;
      tag_r  <= in_detail_tag;
      rank_r <= in_rank;
    end
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    free_r   <= free_nxt;
    evalid_r <= evalid_nxt;
    entry_r  <= entry_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign used_count = used_r;

  always_comb begin
    res.status      = status_r;
    res.slot_free   = free_r;
    res.entry_valid = evalid_r;
    res.entry_time  = entry_r.key;
    res.entry_tag   = entry_r.tag;
    res.entry_count = COUNT_W'(used_r);
  end

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table: holds up to CAPACITY unique 11-bit time keys in ascending order, each
// with a 16-bit tag, in one single-port-write, registered-read memory, and answers insert,
// delete, query and read-at-rank commands with one result item each. An insert, delete or
// query scans the table from rank 0 through one comparator, with a read and a check state
// per entry examined, and an insert or delete then moves the entries behind the position
// one at a time, with a read and a write state per entry, as the memory gives one read and
// one write a cycle. The scan and the move together pass over the table once, while a read
// at rank fetches its entry without a scan. The result waits while the previous one is
// still held in the output register, and the next item is taken in the cycle after the
// result has moved there.
`include "sorted_key_table_assert.svh"

module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic  clk,
  input logic  rst_n,
  skt_in_if.sink    in_if,
  skt_out_if.source out_if
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          in_fire;
  logic          res_valid, res_take;
  skt_res_t      res;
  logic [CW-1:0] used_count;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  skt_entry_t    mem_wdata, mem_rdata;
  logic          out_valid_r;
  skt_res_t      out_r;

  assign in_fire = in_if.valid && in_if.ready;

  skt_seq #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_command    (in_if.command),
    .in_slot_time  (in_if.slot_time),
    .in_detail_tag (in_if.detail_tag),
    .in_rank       (in_if.rank),
    .in_ready      (in_if.ready),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .used_count    (used_count),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  skt_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_r.status;
  assign out_if.slot_free   = out_r.slot_free;
  assign out_if.entry_valid = out_r.entry_valid;
  assign out_if.entry_time  = out_r.entry_time;
  assign out_if.entry_tag   = out_r.entry_tag;
  assign out_if.entry_count = out_r.entry_count;

  `SKT_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_if.ready, "ready after accepting an item")
  `SKT_ASSERT_SAME(a_entry_ok, out_valid_r && out_r.entry_valid, out_r.status == ST_OK, "entry with bad status")
  `SKT_ASSERT_SAME(a_count_bound, 1'b1, 32'(used_count) <= CAPACITY, "entry count above capacity")
  `SKT_ASSERT_NEXT(a_take_loads, res_take, out_valid_r && out_r.entry_count == $past(res.entry_count), "result not loaded")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1928;
  localparam int HOLD_CYCLES  = 400;

  class slot_book;
    logic [KEY_W-1:0] keys[DEPTH];
    logic [TAG_W-1:0] tags[DEPTH];
    int unsigned      used;
    skt_res_t         answers[$];
    int               errors;
    int               cmd_seen[4];
    int               status_seen[5];
    int unsigned      peak;

    function new();
      used   = 0;
      errors = 0;
      peak   = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned locate(logic [KEY_W-1:0] k);
      for (int unsigned i = 0; i < used; i++) begin
        if (keys[i] == k) return i;
      end
      return used;
    endfunction

    function void note_command(skt_cmd_t c, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                               logic [RANK_W-1:0] r);
      skt_res_t    a;
      int unsigned pos;
      a = '0;
      a.status = ST_OK;
      case (c)
        CMD_INSERT: begin
          if (locate(k) < used) begin
            a.status = ST_BOOKED;
          end else if (used >= DEPTH) begin
            a.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < used && keys[pos] < k) pos++;
            for (int unsigned i = used; i > pos; i--) begin
              keys[i] = keys[i-1];
              tags[i] = tags[i-1];
            end
            keys[pos] = k;
            tags[pos] = t;
            used++;
          end
        end
        CMD_DELETE: begin
          if (used == 0) begin
            a.status = ST_EMPTY;
          end else begin
            pos = locate(k);
            if (pos >= used) begin
              a.status = ST_NOT_FOUND;
            end else begin
              for (int unsigned i = pos; i + 1 < used; i++) begin
                keys[i] = keys[i+1];
                tags[i] = tags[i+1];
              end
              used--;
            end
          end
        end
        CMD_QUERY: begin
          a.slot_free = (locate(k) >= used);
        end
        default: begin
          if (used == 0) begin
            a.status = ST_EMPTY;
          end else if (r >= used) begin
            a.status = ST_NOT_FOUND;
          end else begin
            a.entry_valid = 1'b1;
            a.entry_time  = keys[r];
            a.entry_tag   = tags[r];
          end
        end
      endcase
      a.entry_count = used[COUNT_W-1:0];
      if (used > peak) peak = used;
      cmd_seen[c]++;
      status_seen[a.status]++;
      answers.push_back(a);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_answer(skt_res_t got);
      skt_res_t want;
      if (answers.size() == 0) begin
        $error("result item arrived with no command outstanding");
        errors++;
        return;
      end
      want = answers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot_free", want.slot_free, got.slot_free);
      compare_field("entry_valid", want.entry_valid, got.entry_valid);
      compare_field("entry_time", want.entry_time, got.entry_time);
      compare_field("entry_tag", want.entry_tag, got.entry_tag);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_key_table #(.CAPACITY(DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  slot_book sb;
  bit       quiet;
  bit       hold_req;
  int       send_gap_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #10_000_000;
    $display("FAIL sorted_key_table");
    $finish;
  end

  task automatic send_item(input skt_cmd_t c, input logic [KEY_W-1:0] k,
                           input logic [TAG_W-1:0] t, input logic [RANK_W-1:0] r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 13);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command    = c;
    in_ch.slot_time  = k;
    in_ch.detail_tag = t;
    in_ch.rank       = r;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c, k, t, r);
  endtask

  task automatic random_item(input int mode);
    int                roll;
    skt_cmd_t          c;
    logic [KEY_W-1:0]  k;
    logic [TAG_W-1:0]  t;
    logic [RANK_W-1:0] r;
    roll = $urandom_range(0, 99);
    case (mode)
      0: c = roll < 70 ? CMD_INSERT : roll < 80 ? CMD_DELETE : roll < 90 ? CMD_QUERY : CMD_READ;
      1: c = roll < 55 ? CMD_DELETE : roll < 70 ? CMD_INSERT : roll < 85 ? CMD_QUERY : CMD_READ;
      default: c = skt_cmd_t'($urandom_range(0, 3));
    endcase
    roll = $urandom_range(0, 99);
    if (sb.used > 0 && roll < 45) begin
      k = sb.keys[$urandom_range(0, sb.used - 1)];
    end else if (roll < 60) begin
      case ($urandom_range(0, 3))
        0: k = 11'd0;
        1: k = 11'd1439;
        2: k = 11'd1440;
        default: k = 11'd2047;
      endcase
    end else begin
      k = KEY_W'($urandom_range(0, 2047));
    end
    roll = $urandom_range(0, 19);
    t = roll == 0 ? 16'h0000 : roll == 1 ? 16'hFFFF : 16'($urandom_range(0, 65535));
    if (c == CMD_READ && sb.used > 0 && $urandom_range(0, 3) != 0) begin
      r = RANK_W'($urandom_range(0, sb.used - 1));
    end else begin
      r = RANK_W'($urandom_range(0, 15));
    end
    send_item(c, k, t, r);
  endtask

  initial begin
    int stall_pct;
    bit held;
    out_ch.ready = 1'b0;
    stall_pct = 0;
    held = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    for (int cyc = 0; ; cyc++) begin
      if (cyc % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 12;
          default: stall_pct = 33;
        endcase
      end
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    skt_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.slot_free   = out_ch.slot_free;
      got.entry_valid = out_ch.entry_valid;
      got.entry_time  = out_ch.entry_time;
      got.entry_tag   = out_ch.entry_tag;
      got.entry_count = out_ch.entry_count;
      sb.check_answer(got);
    end
  end

  initial begin
    int mode;
    int waited;
    sb               = new();
    quiet            = 1'b0;
    hold_req         = 1'b0;
    send_gap_pct     = 25;
    mode             = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_INSERT;
    in_ch.slot_time  = '0;
    in_ch.detail_tag = '0;
    in_ch.rank       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table first, then the key extremes, duplicates, misses and edge deletions.
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd5,    16'h0000, 4'd0);
    send_item(CMD_QUERY,  11'd0,    16'h0000, 4'd0);
    send_item(CMD_INSERT, 11'd1439, 16'h1234, 4'd0);
    send_item(CMD_INSERT, 11'd0,    16'h0000, 4'd15);
    send_item(CMD_INSERT, 11'd2047, 16'hFFFF, 4'd0);
    send_item(CMD_INSERT, 11'd1440, 16'h5555, 4'd0);
    send_item(CMD_INSERT, 11'd0,    16'hAAAA, 4'd0);
    send_item(CMD_QUERY,  11'd0,    16'h0000, 4'd0);
    send_item(CMD_QUERY,  11'd100,  16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd100,  16'h0000, 4'd0);
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd0);
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd3);
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd4);
    send_item(CMD_READ,   11'd2047, 16'hFFFF, 4'd15);
    send_item(CMD_INSERT, 11'd720,  16'h0001, 4'd0);
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd1);
    send_item(CMD_DELETE, 11'd0,    16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd2047, 16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd720,  16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd1439, 16'h0000, 4'd0);
    send_item(CMD_DELETE, 11'd1440, 16'h0000, 4'd0);
    send_item(CMD_READ,   11'd0,    16'h0000, 4'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        mode = (i < 192) ? 0 : $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0: send_gap_pct = 0;
          1: send_gap_pct = 20;
          default: send_gap_pct = 50;
        endcase
      end
      quiet = (i >= RANDOM_ITEMS - 200);
      if (i == 500) hold_req = 1'b1;
      if (i == 1000) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.answers.size() != 0) @(negedge clk);
      end
      random_item(mode);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (sb.answers.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.answers.size() != 0) begin
      $error("%0d expected result items never arrived", sb.answers.size());
      sb.errors++;
    end

    $display("Covered %0d inserts, %0d deletes, %0d queries and %0d reads.",
             sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DELETE], sb.cmd_seen[CMD_QUERY],
             sb.cmd_seen[CMD_READ]);
    $display("Outcomes: %0d ok, %0d booked, %0d not found, %0d empty, %0d full; peak %0d of %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_BOOKED], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL], sb.peak, DEPTH);
    if (sb.errors == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule
